/* hw/rtl/lir_pkg.sv */
// ----------------------------------------------------------------------------
// lir_pkg: shared constants for the linear interpolation resampler
// Default widths, the fixed step/position widths and the serial digit size.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_RUN_DEF     = 64;

    // step register and position accumulator widths
    localparam int STEP_W = 21;
    localparam int POS_W  = 22;

    // bits of the fraction consumed per cycle by the lerp unit
    localparam int DIGIT_BITS = 4;

endpackage

/* hw/rtl/linear_interp_resampler.sv */
// ----------------------------------------------------------------------------
// linear_interp_resampler: fixed-point linear interpolation resampler
// Accumulates a Q(FRAC_BITS) phase step and emits interpolated samples
// between consecutive source samples, plus a tail run on end of block.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_ready     | sample_in, end_of_block
//   out     | output    | o_out_valid / i_out_ready   | sample_out, run_last,
//           |           |                             | block_done
//   cfg     | input     | i_cfg_wr_en (no wait)       | i_cfg_wr_data (phase step)
//
// One input transaction at a time. A block's first sample that does not end
// the block is only stored; any other input passes through the check state
// before the next input is taken. Each output is computed by the digit-serial
// 4-bit-per-cycle lerp unit; outputs past MAX_RUN are skipped by stepping
// the position in the check state. Reset is synchronous, active low, no
// clearing pass. A stalled output only holds up the next output; the output
// register lets the next input be taken while a result waits.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN     = lir_pkg::MAX_RUN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lir_pkg::STEP_W-1:0]        i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  logic                              i_end_of_block,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    output logic                              o_run_last,
    output logic                              o_block_done
);

    localparam int SW = SAMPLE_BITS;
    localparam int TW = lir_pkg::STEP_W;
    localparam int PW = lir_pkg::POS_W;
    localparam int NW = $clog2(MAX_RUN + 1);

    localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
    localparam logic [PW:0]   ONE_X    = (PW + 1)'(1) << FRAC_BITS;
    localparam logic [PW:0]   TWO_X    = (PW + 1)'(2) << FRAC_BITS;
    localparam logic [TW-1:0] STEP_RST = TW'(1) << FRAC_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_MUL   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [TW-1:0]        r_step;
    logic signed [SW-1:0] r_prev, n_prev;
    logic                 r_have, n_have;
    logic [PW-1:0]        r_pos, n_pos;
    logic signed [SW-1:0] r_cur, n_cur;
    logic                 r_eob, n_eob;
    logic                 r_phase_b, n_phase_b;
    logic signed [SW-1:0] r_a, n_a;
    logic signed [SW:0]   r_d, n_d;
    logic [NW-1:0]        r_n, n_n;
    logic                 r_ovalid, n_ovalid;
    logic signed [SW-1:0] r_osample, n_osample;
    logic                 r_orun, n_orun;
    logic                 r_odone, n_odone;

    logic [TW-1:0]        w_step;
    logic [PW:0]          w_pos_adv;
    logic                 w_last;
    logic                 w_start;
    logic                 w_mul_done;
    logic signed [SW-1:0] w_mul_res;
    logic                 w_in_acc;

    assign w_step    = (r_step == '0) ? TW'(1) : r_step;
    assign w_pos_adv = (PW + 1)'(r_pos) + (PW + 1)'(w_step);
    // last of this run: next position passes every interval left, or output MAX_RUN
    assign w_last    = (w_pos_adv >= ((r_eob && !r_phase_b) ? TWO_X : ONE_X))
                     || (r_n == NW'(MAX_RUN - 1));
    assign w_in_acc  = i_in_valid && o_in_ready;

    lir_lerp #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (r_a),
        .i_d     (r_d),
        .i_frac  (r_pos[FRAC_BITS-1:0]),
        .o_done  (w_mul_done),
        .o_result(w_mul_res)
    );

    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_have    = r_have;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_eob     = r_eob;
        n_phase_b = r_phase_b;
        n_a       = r_a;
        n_d       = r_d;
        n_n       = r_n;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_osample = r_osample;
        n_orun    = r_orun;
        n_odone   = r_odone;
        w_start   = 1'b0;
        o_in_ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cur  = i_sample_in;
                    n_eob  = i_end_of_block;
                    n_n    = '0;
                    n_prev = i_sample_in;
                    n_have = 1'b1;
                    if (r_have) begin
                        n_a       = r_prev;
                        n_d       = (SW + 1)'(i_sample_in) - (SW + 1)'(r_prev);
                        n_phase_b = 1'b0;
                        n_state   = S_CHECK;
                    end else if (i_end_of_block) begin
                        n_a       = i_sample_in;
                        n_d       = '0;
                        n_phase_b = 1'b1;
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_pos < ONE) begin
                    if (r_n == NW'(MAX_RUN)) begin
                        // run is full: step past the dropped outputs
                        n_pos = w_pos_adv[PW-1:0];
                    end else begin
                        w_start = 1'b1;
                        n_state = S_MUL;
                    end
                end else begin
                    n_pos = r_pos - ONE;
                    if (r_eob && !r_phase_b) begin
                        // tail: hold the last sample
                        n_phase_b = 1'b1;
                        n_a       = r_cur;
                        n_d       = '0;
                    end else begin
                        if (r_eob) begin
                            n_prev = '0;
                            n_have = 1'b0;
                            n_pos  = '0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            S_MUL: begin
                if (w_mul_done && (!r_ovalid || i_out_ready)) begin
                    n_ovalid  = 1'b1;
                    n_osample = w_mul_res;
                    n_orun    = w_last;
                    n_odone   = w_last && r_eob;
                    n_n       = r_n + NW'(1);
                    n_pos     = w_pos_adv[PW-1:0];
                    n_state   = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= STEP_RST;
            r_prev   <= '0;
            r_have   <= 1'b0;
            r_pos    <= '0;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            r_prev   <= n_prev;
            r_have   <= n_have;
            r_pos    <= n_pos;
            r_n      <= n_n;
            r_ovalid <= n_ovalid;
        end
        r_cur     <= n_cur;
        r_eob     <= n_eob;
        r_phase_b <= n_phase_b;
        r_a       <= n_a;
        r_d       <= n_d;
        r_osample <= n_osample;
        r_orun    <= n_orun;
        r_odone   <= n_odone;
    end

    assign o_out_valid  = r_ovalid;
    assign o_sample_out = r_osample;
    assign o_run_last   = r_orun;
    assign o_block_done = r_odone;

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_RUN))
        else $error("output run count exceeds MAX_RUN");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_block_done |-> o_run_last)
        else $error("block_done without run_last");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !r_have |-> (r_pos == '0) && (r_prev == '0))
        else $error("state not cleared between blocks");

    a_mul_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_pos < ONE))
        else $error("interpolation with position past the interval");

    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !w_mul_done)
        else $error("lerp done flag not cleared on start");

endmodule

/* hw/rtl/lir_lerp.sv */
// ----------------------------------------------------------------------------
// lir_lerp: digit-serial linear interpolation unit
// Computes a + round_half_up(d * frac / 2^FRAC_BITS), saturated, consuming
// DIGIT_BITS bits of frac per cycle (LSB digit first, right-shift product).
// ----------------------------------------------------------------------------
module lir_lerp #(
    parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS:0]   i_d,
    input  logic        [FRAC_BITS-1:0]   i_frac,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_result
);

    localparam int SW   = SAMPLE_BITS;
    localparam int DIG  = lir_pkg::DIGIT_BITS;
    localparam int NDIG = (FRAC_BITS + DIG - 1) / DIG;
    localparam int LW   = NDIG * DIG;
    localparam int HW   = SW + DIG + 2;
    localparam int PW   = HW + LW;
    localparam int CW   = $clog2(NDIG);
    localparam int RW   = SW + 3;

    localparam logic signed [RW-1:0] SMAX = RW'((2 ** (SW - 1)) - 1);
    localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

    logic                 r_busy, n_busy;
    logic                 r_fin, n_fin;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [HW-1:0] r_hi, n_hi;
    logic [LW-1:0]        r_lo, n_lo;
    logic [LW-1:0]        r_frac, n_frac;
    logic signed [SW:0]   r_d, n_d;
    logic signed [SW-1:0] r_a, n_a;

    logic [DIG-1:0]       w_digit;
    logic signed [HW-1:0] w_prod;
    logic signed [HW-1:0] w_sum;
    logic signed [PW-1:0] w_p;
    logic signed [PW-1:0] w_q;
    logic signed [RW-1:0] w_res;

    assign w_digit = r_frac[DIG-1:0];
    assign w_prod  = HW'(r_d) * HW'($signed({1'b0, w_digit}));
    assign w_sum   = r_hi + w_prod;

    always_comb begin
        n_busy = r_busy;
        n_fin  = r_fin;
        n_cnt  = r_cnt;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_frac = r_frac;
        n_d    = r_d;
        n_a    = r_a;
        if (i_start) begin
            n_busy = 1'b1;
            n_fin  = 1'b0;
            n_cnt  = '0;
            n_hi   = '0;
            n_lo   = '0;
            n_frac = LW'(i_frac);
            n_d    = i_d;
            n_a    = i_a;
        end else if (r_busy) begin
            n_lo   = {w_sum[DIG-1:0], r_lo[LW-1:DIG]};
            n_hi   = w_sum >>> DIG;
            n_frac = r_frac >> DIG;
            n_cnt  = r_cnt + CW'(1);
            if (r_cnt == CW'(NDIG - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_cnt  <= n_cnt;
        end
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_frac <= n_frac;
        r_d    <= n_d;
        r_a    <= n_a;
    end

    // floor(p / 2^F) plus the half bit gives round half up
    assign w_p   = {r_hi, r_lo};
    assign w_q   = w_p >>> FRAC_BITS;
    assign w_res = RW'(r_a) + RW'($signed(w_q[SW+1:0]))
                 + RW'($signed({1'b0, r_lo[FRAC_BITS-1]}));

    always_comb begin
        if (w_res > SMAX) begin
            o_result = SMAX[SW-1:0];
        end else if (w_res < SMIN) begin
            o_result = SMIN[SW-1:0];
        end else begin
            o_result = w_res[SW-1:0];
        end
    end

    assign o_done = r_fin;

endmodule
